FILE: rtl/core/sipd_pkg.sv
// shared types and constants for the signed integer to padded decimal converter
package sipd_pkg;

  localparam int MagBits   = 32;
  localparam int BcdDigits = 10;
  localparam int BcdBits   = 4 * BcdDigits;
  localparam int CharBits  = 8;
  localparam int WidthBits = 7;
  localparam int NdBits    = 4;
  localparam int CntBits   = 5;

  localparam logic [CharBits-1:0] CH_ZERO  = 8'd48;
  localparam logic [CharBits-1:0] CH_MINUS = 8'd45;
  localparam logic [CharBits-1:0] CH_BLANK = 8'd32;

  localparam logic [CntBits-1:0] LAST_SHIFT = 5'(MagBits - 1);
  localparam logic [NdBits-1:0]  ND_FULL    = 4'(BcdDigits);

  typedef struct packed {
    logic [BcdBits-1:0] bcd;
    logic               neg;
  } conv_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_NORM,
    E_PAD,
    E_SIGN,
    E_DIGIT
  } emit_state_t;

endpackage

FILE: rtl/core/signed_int_to_padded_decimal.sv
// top level: signed 32-bit integer to blank-padded decimal ascii text
//
// channel   signals                          transaction
// input     start, busy, value               start high while busy low
// result    strobe, char_code, last_char     strobe high, one character per cycle
// config    cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready both high
//
// one number goes through bit-serial bcd conversion (one magnitude bit a cycle), then
// the stripping of leading zero digits and the sizing of the padding, then one character
// a cycle is sent; the next start is taken the cycle after the last character.
// busy stays high from the accepted start until the last character has gone out.
// rst is synchronous and clears the width register and all sequencing state.
// results cannot be stalled; each character is on the ports for exactly one cycle.
module signed_int_to_padded_decimal #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sipd_pkg::MagBits-1:0]   value,
  output logic                                  strobe,
  output logic [sipd_pkg::CharBits-1:0]         char_code,
  output logic                                  last_char,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sipd_pkg::WidthBits-1:0]        cfg_data
);

  localparam logic [sipd_pkg::WidthBits-1:0] WidthCap = sipd_pkg::WidthBits'(MAX_WIDTH);

  logic [sipd_pkg::WidthBits-1:0] min_width;
  logic [sipd_pkg::WidthBits-1:0] eff_width;
  logic                           load;
  logic                           conv_busy;
  logic                           conv_done;
  logic                           emit_busy;
  sipd_pkg::conv_t                conv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_width <= cfg_data;
    end
  end

  assign eff_width = (min_width > WidthCap) ? WidthCap : min_width;
  assign busy      = conv_busy | emit_busy;
  assign load      = start & ~busy;

  sipd_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .value  (value),
    .busy   (conv_busy),
    .done   (conv_done),
    .result (conv)
  );

  sipd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (conv_done),
    .conv      (conv),
    .width     (eff_width),
    .busy      (emit_busy),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

FILE: rtl/core/sipd_dabble.sv
// bit-serial binary to bcd converter, one magnitude bit per cycle
module sipd_dabble (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic signed [sipd_pkg::MagBits-1:0] value,
  output logic                              busy,
  output logic                              done,
  output sipd_pkg::conv_t                   result
);

  logic [sipd_pkg::MagBits-1:0] mag;
  logic [sipd_pkg::BcdBits-1:0] bcd;
  logic [sipd_pkg::BcdBits-1:0] bcd_adj;
  logic                         neg;
  logic [sipd_pkg::CntBits-1:0] cnt;
  logic                         running;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < sipd_pkg::BcdDigits; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == sipd_pkg::LAST_SHIFT) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= value[sipd_pkg::MagBits-1];
      bcd <= '0;
      if (value[sipd_pkg::MagBits-1]) begin
        mag <= 32'd0 - 32'(value);
      end else begin
        mag <= 32'(value);
      end
    end else if (running) begin
      {bcd, mag} <= {bcd_adj[sipd_pkg::BcdBits-2:0], mag, 1'b0};
    end
  end

  assign busy       = running | done;
  assign result.bcd = bcd;
  assign result.neg = neg;

endmodule

FILE: rtl/core/sipd_emitter.sv
// character sequencer: strips leading zero digits, then sends blanks, sign and digits
module sipd_emitter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  sipd_pkg::conv_t                     conv,
  input  logic [sipd_pkg::WidthBits-1:0]      width,
  output logic                                busy,
  output logic                                strobe,
  output logic [sipd_pkg::CharBits-1:0]       char_code,
  output logic                                last_char
);

  sipd_pkg::emit_state_t state, state_next;

  logic [sipd_pkg::BcdBits-1:0]   bcd, bcd_next;
  logic [sipd_pkg::NdBits-1:0]    nd, nd_next;
  logic [sipd_pkg::WidthBits-1:0] pad, pad_next;
  logic                           neg;

  logic [3:0]                     top_digit;
  logic                           norm_done;
  logic [sipd_pkg::WidthBits-1:0] text_len;
  logic [sipd_pkg::WidthBits-1:0] pad_calc;

  assign top_digit = bcd[sipd_pkg::BcdBits-1 -: 4];
  assign norm_done = (top_digit != 4'd0) || (nd == 4'd1);
  assign text_len  = sipd_pkg::WidthBits'(nd) + sipd_pkg::WidthBits'(neg);
  assign pad_calc  = (width > text_len) ? (width - text_len) : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sipd_pkg::E_IDLE: begin
        if (load) begin
          state_next = sipd_pkg::E_NORM;
        end
      end
      sipd_pkg::E_NORM: begin
        if (norm_done) begin
          if (pad_calc != '0) begin
            state_next = sipd_pkg::E_PAD;
          end else if (neg) begin
            state_next = sipd_pkg::E_SIGN;
          end else begin
            state_next = sipd_pkg::E_DIGIT;
          end
        end
      end
      sipd_pkg::E_PAD: begin
        if (pad == 7'd1) begin
          state_next = neg ? sipd_pkg::E_SIGN : sipd_pkg::E_DIGIT;
        end
      end
      sipd_pkg::E_SIGN: begin
        state_next = sipd_pkg::E_DIGIT;
      end
      sipd_pkg::E_DIGIT: begin
        if (nd == 4'd1) begin
          state_next = sipd_pkg::E_IDLE;
        end
      end
      default: state_next = sipd_pkg::E_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    bcd_next = bcd;
    nd_next  = nd;
    pad_next = pad;
    unique case (state)
      sipd_pkg::E_IDLE: begin
        bcd_next = conv.bcd;
        nd_next  = sipd_pkg::ND_FULL;
      end
      sipd_pkg::E_NORM: begin
        if (norm_done) begin
          pad_next = pad_calc;
        end else begin
          bcd_next = {bcd[sipd_pkg::BcdBits-5:0], 4'd0};
          nd_next  = nd - 1'b1;
        end
      end
      sipd_pkg::E_PAD: begin
        pad_next = pad - 1'b1;
      end
      sipd_pkg::E_SIGN: begin
        pad_next = pad;
      end
      sipd_pkg::E_DIGIT: begin
        bcd_next = {bcd[sipd_pkg::BcdBits-5:0], 4'd0};
        nd_next  = nd - 1'b1;
      end
      default: bcd_next = bcd;
    endcase
  end

  // outputs
  always_comb begin
    strobe    = 1'b0;
    char_code = sipd_pkg::CH_BLANK;
    last_char = 1'b0;
    unique case (state)
      sipd_pkg::E_IDLE, sipd_pkg::E_NORM: begin
        strobe = 1'b0;
      end
      sipd_pkg::E_PAD: begin
        strobe    = 1'b1;
        char_code = sipd_pkg::CH_BLANK;
      end
      sipd_pkg::E_SIGN: begin
        strobe    = 1'b1;
        char_code = sipd_pkg::CH_MINUS;
      end
      sipd_pkg::E_DIGIT: begin
        strobe    = 1'b1;
        char_code = sipd_pkg::CH_ZERO + {4'd0, top_digit};
        last_char = (nd == 4'd1);
      end
      default: strobe = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sipd_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bcd <= bcd_next;
    nd  <= nd_next;
    pad <= pad_next;
    if (state == sipd_pkg::E_IDLE) begin
      neg <= conv.neg;
    end
  end

  assign busy = (state != sipd_pkg::E_IDLE);

endmodule
